### rtl/core/gsc_pkg.sv
// Package for the greedy search candidate list.
// Holds command codes, scan modes, word types and size constants; no dependencies.
package gsc_pkg;

  localparam int unsigned MaxListDef = 64;
  localparam int unsigned MaxOut     = 64;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned NodeW      = 32;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam logic [KeyW-1:0] SignFlip = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_DRAIN  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIST_SIZE    = 2'd0,
    REG_RESULT_COUNT = 2'd1
  } reg_e;

  typedef enum logic [1:0] {
    MODE_MAX       = 2'd0,
    MODE_MIN_OPEN  = 2'd1,
    MODE_MIN_AFTER = 2'd2
  } mode_e;

  typedef struct packed {
    logic              found;
    logic [KeyW-1:0]   key;
    logic [NodeW-1:0]  node;
  } scan_t;

  typedef struct packed {
    mode_e             mode;
    logic              thr_valid;
    logic [KeyW-1:0]   thr_key;
  } ctrl_t;

endpackage

### rtl/core/gsc_in_if.sv
// Command channel interface of the candidate list.
// Depends on gsc_pkg.
interface gsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [gsc_pkg::NodeW-1:0] node_id;
  logic signed [gsc_pkg::KeyW-1:0] distance;

  modport source (output valid, cmd, node_id, distance, input ready);
  modport sink   (input valid, cmd, node_id, distance, output ready);
endinterface

### rtl/core/gsc_out_if.sv
// Result channel interface of the candidate list.
// Depends on gsc_pkg.
interface gsc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      valid_res;
  logic [gsc_pkg::NodeW-1:0] result_id;
  logic signed [gsc_pkg::KeyW-1:0] result_distance;
  logic                      last;

  modport source (output valid, valid_res, result_id, result_distance, last, input ready);
  modport sink   (input valid, valid_res, result_id, result_distance, last, output ready);
endinterface

### rtl/core/greedy_search_candidate_list.sv
// Candidate list for a graph greedy search: command sink, result source, config writes.
// A word on in_if carries cmd, node_id and distance; out_if returns valid_res, result_id,
// result_distance and last. Clear returns no word, insert and select return one word,
// drain returns min(result_count, fill, 64) words in ascending distance (one word with
// valid_res low when that count is zero).
// Commands are taken one at a time: in_if.ready is high only while the block is idle.
// An insert into a list with room answers in the cycle after it is taken. A full insert, a
// select and each drain word pass one scan through the chain of MAX_LIST slot cells, one
// cell per cycle. The result word is held in an output register until out_if.ready; the
// block waits and keeps its state while the receiver stalls.
// Reset empties the list and loads list_size 32 and result_count 10. Slot contents
// need no clearing; only slots below the fill count are ever read.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must
// write it only while idle, and the block itself does not enforce this.
// Depends on gsc_pkg, gsc_in_if, gsc_out_if and gsc_cell.
module greedy_search_candidate_list #(
  parameter int unsigned MAX_LIST = gsc_pkg::MaxListDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gsc_in_if.sink                        in_if,
  gsc_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [gsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gsc_pkg::CfgW-1:0]      cfg_wdata_i
);

  localparam int unsigned IdxW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int unsigned CntW = $clog2(MAX_LIST + 1);
  localparam int unsigned CW   = (CntW > gsc_pkg::CfgW) ? CntW : gsc_pkg::CfgW;
  localparam int unsigned OutW = $clog2(gsc_pkg::MaxOut + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [gsc_pkg::CfgW-1:0]    list_size_q, result_count_q;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             scan_cnt_q, scan_cnt_d;
  gsc_pkg::cmd_e               cmd_q, cmd_d;
  logic [gsc_pkg::NodeW-1:0]   new_node_q, new_node_d;
  logic [gsc_pkg::KeyW-1:0]    new_key_q, new_key_d;
  gsc_pkg::ctrl_t              ctrl_q, ctrl_d;
  logic [IdxW-1:0]             thr_idx_q, thr_idx_d;
  logic [OutW-1:0]             drain_cnt_q, drain_cnt_d, emitted_q, emitted_d;
  logic                        more_q, more_d;
  logic                        ovalid_q, ovalid_d, ores_q, ores_d, olast_q, olast_d;
  logic [gsc_pkg::NodeW-1:0]   oid_q, oid_d;
  logic [gsc_pkg::KeyW-1:0]    okey_q, okey_d;

  logic                        wr_en, done_set;
  logic [IdxW-1:0]             wr_idx;
  logic [gsc_pkg::NodeW-1:0]   wr_node;
  logic [gsc_pkg::KeyW-1:0]    wr_key;
  logic [CW-1:0]               cap, dmin;
  logic                        in_acc, is_last;
  gsc_pkg::scan_t              res;
  logic [IdxW-1:0]             res_idx;

  gsc_pkg::scan_t              chain   [MAX_LIST+1];
  logic [IdxW-1:0]             chain_i [MAX_LIST+1];

  assign chain[0]   = '0;
  assign chain_i[0] = '0;

  for (genvar g = 0; g < MAX_LIST; g++) begin : g_cell
    gsc_cell #(
      .IdxW  (IdxW),
      .CntW  (CntW),
      .Index (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_q),
      .thr_idx_i  (thr_idx_q),
      .fill_i     (fill_q),
      .wr_en_i    (wr_en),
      .done_set_i (done_set),
      .wr_idx_i   (wr_idx),
      .wr_node_i  (wr_node),
      .wr_key_i   (wr_key),
      .scan_i     (chain[g]),
      .scan_idx_i (chain_i[g]),
      .scan_o     (chain[g+1]),
      .scan_idx_o (chain_i[g+1])
    );
  end

  assign res     = chain[MAX_LIST];
  assign res_idx = chain_i[MAX_LIST];

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && (state_q == ST_IDLE);

  always_comb begin
    if (list_size_q == '0) begin
      cap = CW'(1);
    end else if (CW'(list_size_q) > CW'(MAX_LIST)) begin
      cap = CW'(MAX_LIST);
    end else begin
      cap = CW'(list_size_q);
    end
    dmin = (CW'(result_count_q) < CW'(fill_q)) ? CW'(result_count_q) : CW'(fill_q);
    if (dmin > CW'(gsc_pkg::MaxOut)) begin
      dmin = CW'(gsc_pkg::MaxOut);
    end
  end

  assign is_last = ((emitted_q + OutW'(1)) == drain_cnt_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    scan_cnt_d  = scan_cnt_q;
    cmd_d       = cmd_q;
    new_node_d  = new_node_q;
    new_key_d   = new_key_q;
    ctrl_d      = ctrl_q;
    thr_idx_d   = thr_idx_q;
    drain_cnt_d = drain_cnt_q;
    emitted_d   = emitted_q;
    more_d      = more_q;
    ovalid_d    = ovalid_q;
    ores_d      = ores_q;
    olast_d     = olast_q;
    oid_d       = oid_q;
    okey_d      = okey_q;
    wr_en       = 1'b0;
    done_set    = 1'b0;
    wr_idx      = IdxW'(fill_q);
    wr_node     = in_if.node_id;
    wr_key      = in_if.distance ^ gsc_pkg::SignFlip;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d      = gsc_pkg::cmd_e'(in_if.cmd);
          new_node_d = in_if.node_id;
          new_key_d  = in_if.distance ^ gsc_pkg::SignFlip;
          scan_cnt_d = '0;
          more_d     = 1'b0;
          ores_d     = 1'b0;
          oid_d      = '0;
          okey_d     = '0;
          olast_d    = 1'b1;
          case (gsc_pkg::cmd_e'(in_if.cmd))
            gsc_pkg::CMD_CLEAR: begin
              fill_d = '0;
            end
            gsc_pkg::CMD_INSERT: begin
              if (CW'(fill_q) < cap) begin
                wr_en    = 1'b1;
                fill_d   = fill_q + CntW'(1);
                ores_d   = 1'b1;
                ovalid_d = 1'b1;
                state_d  = ST_OUT;
              end else begin
                ctrl_d.mode = gsc_pkg::MODE_MAX;
                state_d     = ST_SCAN;
              end
            end
            gsc_pkg::CMD_SELECT: begin
              ctrl_d.mode = gsc_pkg::MODE_MIN_OPEN;
              state_d     = ST_SCAN;
            end
            gsc_pkg::CMD_DRAIN: begin
              drain_cnt_d = OutW'(dmin);
              emitted_d   = '0;
              if (dmin == '0) begin
                ovalid_d = 1'b1;
                state_d  = ST_OUT;
              end else begin
                ctrl_d.mode      = gsc_pkg::MODE_MIN_AFTER;
                ctrl_d.thr_valid = 1'b0;
                state_d          = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q == CntW'(MAX_LIST)) begin
          ovalid_d = 1'b1;
          state_d  = ST_OUT;
          wr_idx   = res_idx;
          wr_node  = new_node_q;
          wr_key   = new_key_q;
          case (cmd_q)
            gsc_pkg::CMD_INSERT: begin
              if (res.found && (new_key_q < res.key)) begin
                wr_en  = 1'b1;
                ores_d = 1'b1;
              end
            end
            gsc_pkg::CMD_SELECT: begin
              if (res.found) begin
                done_set = 1'b1;
                ores_d   = 1'b1;
                oid_d    = res.node;
                okey_d   = res.key ^ gsc_pkg::SignFlip;
              end
            end
            default: begin
              ores_d           = 1'b1;
              oid_d            = res.node;
              okey_d           = res.key ^ gsc_pkg::SignFlip;
              olast_d          = is_last;
              more_d           = !is_last;
              emitted_d        = emitted_q + OutW'(1);
              ctrl_d.thr_valid = 1'b1;
              ctrl_d.thr_key   = res.key;
              thr_idx_d        = res_idx;
            end
          endcase
        end else begin
          scan_cnt_d = scan_cnt_q + CntW'(1);
        end
      end
      ST_OUT: begin
        if (out_if.ready) begin
          ovalid_d   = 1'b0;
          scan_cnt_d = '0;
          state_d    = more_q ? ST_SCAN : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      fill_q         <= '0;
      scan_cnt_q     <= '0;
      ovalid_q       <= 1'b0;
      more_q         <= 1'b0;
      emitted_q      <= '0;
      drain_cnt_q    <= '0;
      ctrl_q         <= '{mode: gsc_pkg::MODE_MAX, thr_valid: 1'b0, thr_key: '0};
      cmd_q          <= gsc_pkg::CMD_CLEAR;
      list_size_q    <= gsc_pkg::CfgW'(32);
      result_count_q <= gsc_pkg::CfgW'(10);
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scan_cnt_q  <= scan_cnt_d;
      ovalid_q    <= ovalid_d;
      more_q      <= more_d;
      emitted_q   <= emitted_d;
      drain_cnt_q <= drain_cnt_d;
      ctrl_q      <= ctrl_d;
      cmd_q       <= cmd_d;
      if (cfg_we_i && (cfg_idx_i == gsc_pkg::REG_LIST_SIZE)) begin
        list_size_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == gsc_pkg::REG_RESULT_COUNT)) begin
        result_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_node_q <= new_node_d;
    new_key_q  <= new_key_d;
    thr_idx_q  <= thr_idx_d;
    ores_q     <= ores_d;
    olast_q    <= olast_d;
    oid_q      <= oid_d;
    okey_q     <= okey_d;
  end

  assign out_if.valid           = ovalid_q;
  assign out_if.valid_res       = ores_q;
  assign out_if.result_id       = oid_q;
  assign out_if.result_distance = okey_q;
  assign out_if.last            = olast_q;

endmodule

### rtl/core/gsc_cell.sv
// One slot of the candidate list with its stage of the scan chain.
// Depends on gsc_pkg.
module gsc_cell #(
  parameter int unsigned IdxW  = 6,
  parameter int unsigned CntW  = 7,
  parameter int unsigned Index = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gsc_pkg::ctrl_t             ctrl_i,
  input  logic [IdxW-1:0]            thr_idx_i,
  input  logic [CntW-1:0]            fill_i,
  input  logic                       wr_en_i,
  input  logic                       done_set_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  input  logic [gsc_pkg::NodeW-1:0]  wr_node_i,
  input  logic [gsc_pkg::KeyW-1:0]   wr_key_i,
  input  gsc_pkg::scan_t             scan_i,
  input  logic [IdxW-1:0]            scan_idx_i,
  output gsc_pkg::scan_t             scan_o,
  output logic [IdxW-1:0]            scan_idx_o
);

  logic [gsc_pkg::NodeW-1:0] node_q;
  logic [gsc_pkg::KeyW-1:0]  key_q;
  logic                      done_q;
  gsc_pkg::scan_t            scan_q, scan_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      hit, active, qual, better;

  assign hit    = (wr_idx_i == IdxW'(Index));
  assign active = (CntW'(Index) < fill_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && hit) begin
      node_q <= wr_node_i;
      key_q  <= wr_key_i;
      done_q <= 1'b0;
    end else if (done_set_i && hit) begin
      done_q <= 1'b1;
    end
  end

  always_comb begin
    case (ctrl_i.mode)
      gsc_pkg::MODE_MAX:       qual = 1'b1;
      gsc_pkg::MODE_MIN_OPEN:  qual = !done_q;
      gsc_pkg::MODE_MIN_AFTER: qual = !ctrl_i.thr_valid || (key_q > ctrl_i.thr_key) ||
                                      ((key_q == ctrl_i.thr_key) &&
                                       (IdxW'(Index) > thr_idx_i));
      default:                 qual = 1'b0;
    endcase
    if (ctrl_i.mode == gsc_pkg::MODE_MAX) begin
      better = !scan_i.found || (key_q > scan_i.key);
    end else begin
      better = !scan_i.found || (key_q < scan_i.key);
    end
    if (active && qual && better) begin
      scan_d.found = 1'b1;
      scan_d.key   = key_q;
      scan_d.node  = node_q;
      idx_d        = IdxW'(Index);
    end else begin
      scan_d = scan_i;
      idx_d  = scan_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      idx_q  <= '0;
    end else begin
      scan_q <= scan_d;
      idx_q  <= idx_d;
    end
  end

  assign scan_o     = scan_q;
  assign scan_idx_o = idx_q;

endmodule
